@@ src/dlmb_pkg.sv @@
// ----------------------------------------------------------------------------
// dlmb_pkg - shared types and constants
// register indexes, field widths and the bounding box result word
// ----------------------------------------------------------------------------
package dlmb_pkg;

  localparam int POS_W   = 12;
  localparam int DIM_W   = 13;
  localparam int DIMX_W  = 14;
  localparam int MM_W    = 16;
  localparam int MAX_DIM = 4096;

  typedef enum logic [7:0] {
    REG_NEAR   = 8'd0,
    REG_FAR    = 8'd1,
    REG_WIDTH  = 8'd2,
    REG_HEIGHT = 8'd3
  } reg_idx_t;

  typedef struct packed {
    logic             frame_end;
    logic             empty;
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
  } box_t;

endpackage

@@ src/depth_linearize_mask_bbox.sv @@
// ----------------------------------------------------------------------------
// depth_linearize_mask_bbox - depth buffer linearization with bounding box
// converts depth codes to millimetres, masks far pixels, tracks a near box
// ----------------------------------------------------------------------------
//  channel | ports                              | direction
//  in      | in_valid/in_ready, in_depth_code   | word in, one pixel
//  out     | out_valid/out_ready, out_* fields  | word out, one per pixel
//  cfg     | cfg_valid/cfg_ready, index, data   | register write, always ready
//
//  one pixel is in flight at a time: from accept to result it passes three
//  setup stages, a chain of 16 restoring division cells, the chain end
//  register and the output register; a finished word parks in the output
//  register, so the next pixel is taken while it waits; the chain end holds
//  if the output is still occupied
//  reset (synchronous, active low) restores the register defaults, clears
//  the raster position and the box
module depth_linearize_mask_bbox #(
  parameter int DEPTH_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [DEPTH_BITS-1:0]       in_depth_code,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [15:0]                 out_depth_mm,
  output logic                        out_in_mask,
  output logic                        out_frame_end,
  output logic                        out_box_empty,
  output logic [11:0]                 out_box_x,
  output logic [11:0]                 out_box_y,
  output logic [12:0]                 out_box_w,
  output logic [12:0]                 out_box_h,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [7:0]                  cfg_index,
  input  logic [15:0]                 cfg_data
);

  localparam int DB    = DEPTH_BITS;
  localparam int W     = DB + 34;   // covers f*n*D and den shifted by 15
  localparam int NCELL = dlmb_pkg::MM_W;
  localparam int DX    = dlmb_pkg::DIMX_W;

  // configuration registers
  logic [15:0] near_r, far_r;
  logic [12:0] fw_r, fh_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_r <= 16'd100;
      far_r  <= 16'd10000;
      fw_r   <= 13'd640;
      fh_r   <= 13'd480;
    end else if (cfg_valid) begin
      case (cfg_index)
        dlmb_pkg::REG_NEAR:   near_r <= cfg_data;
        dlmb_pkg::REG_FAR:    far_r  <= cfg_data;
        dlmb_pkg::REG_WIDTH:  fw_r   <= cfg_data[12:0];
        dlmb_pkg::REG_HEIGHT: fh_r   <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // frame size clamped to 1..MAX_DIM
  logic [DX-1:0] dim_w, dim_h;
  always_comb begin
    dim_w = DX'(fw_r);
    if (fw_r == '0) dim_w = DX'(1);
    else if (DX'(fw_r) > DX'(dlmb_pkg::MAX_DIM)) dim_w = DX'(dlmb_pkg::MAX_DIM);
    dim_h = DX'(fh_r);
    if (fh_r == '0) dim_h = DX'(1);
    else if (DX'(fh_r) > DX'(dlmb_pkg::MAX_DIM)) dim_h = DX'(dlmb_pkg::MAX_DIM);
  end

  // flow control: one pixel between accept and output register
  logic busy_r, accept, deliver;
  assign in_ready = !busy_r;
  assign accept   = in_valid && in_ready;

  // stage 1: capture operands
  logic          v1_r;
  logic [DB-1:0] c1_r;
  logic [15:0]   n1_r, f1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else        v1_r <= accept;
    c1_r <= in_depth_code;
    n1_r <= near_r;
    f1_r <= far_r;
  end

  // stage 2: the two real multiplies, code by plane gap and far by near
  logic            v2_r, ge2_r;
  logic [15:0]     n2_r, f2_r;
  logic [DB+15:0]  prod2_r;
  logic [31:0]     fn2_r;
  logic [15:0]     gap;

  assign gap = (f1_r >= n1_r) ? f1_r - n1_r : n1_r - f1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else        v2_r <= v1_r;
    ge2_r   <= f1_r >= n1_r;
    n2_r    <= n1_r;
    f2_r    <= f1_r;
    prod2_r <= (DB+16)'(c1_r) * (DB+16)'(gap);
    fn2_r   <= 32'(f1_r) * 32'(n1_r);
  end

  // stage 3: denominator, numerator and scaled near term (shift and subtract by D)
  logic          v3_r, fz3_r;
  logic [W-1:0]  den3_r, num3_r, nd3_r;
  logic [W-1:0]  fd, nd;

  assign fd = (W'(f2_r) << DB) - W'(f2_r);
  assign nd = (W'(n2_r) << DB) - W'(n2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else        v3_r <= v2_r;
    fz3_r  <= f2_r == '0;
    den3_r <= ge2_r ? fd - W'(prod2_r) : fd + W'(prod2_r);
    num3_r <= (W'(fn2_r) << DB) - W'(fn2_r);
    nd3_r  <= nd * W'(100);
  end

  // far test on the unrounded depth, held for the pixel in flight
  logic beyond_r;
  always_ff @(posedge clk) begin
    if (v3_r) beyond_r <= (den3_r == '0) || (!fz3_r && (nd3_r > den3_r * W'(99)));
  end

  // division chain: quotient never exceeds 16 bits since den >= min(f,n)*D
  logic              cv   [NCELL+1];
  logic [NCELL-1:0]  cq   [NCELL+1];
  logic [W-1:0]      crem [NCELL+1];
  logic [W-1:0]      cden [NCELL+1];

  assign cv[0]   = v3_r;
  assign cq[0]   = '0;
  assign crem[0] = num3_r;
  assign cden[0] = den3_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    dlmb_cell #(.W(W), .SH(NCELL-1-i)) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .in_v    (cv[i]),
      .in_q    (cq[i]),
      .in_rem  (crem[i]),
      .in_den  (cden[i]),
      .out_v   (cv[i+1]),
      .out_q   (cq[i+1]),
      .out_rem (crem[i+1]),
      .out_den (cden[i+1])
    );
  end

  // chain end parks here until the output register is free
  logic             done_r;
  logic [NCELL-1:0] q_r;
  logic [W-1:0]     rem_r, den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) done_r <= 1'b0;
    else if (cv[NCELL]) done_r <= 1'b1;
    else if (deliver)   done_r <= 1'b0;
    if (cv[NCELL]) begin
      q_r   <= cq[NCELL];
      rem_r <= crem[NCELL];
      den_r <= cden[NCELL];
    end
  end

  assign deliver = done_r && (!out_valid || out_ready);

  // round half up, saturate at 16 bits, zero for a pixel beyond the far limit
  logic [NCELL:0]  q_rnd;
  logic [15:0]     depth;
  assign q_rnd = {1'b0, q_r} + (NCELL+1)'((rem_r << 1) >= den_r);
  assign depth = beyond_r ? '0 : (q_rnd[NCELL] ? '1 : q_rnd[15:0]);

  // raster position and box
  dlmb_pkg::box_t box;
  dlmb_box u_box (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (deliver),
    .mask  (!beyond_r),
    .dim_w (dim_w),
    .dim_h (dim_h),
    .box   (box)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (accept)       busy_r <= 1'b1;
      else if (deliver) busy_r <= 1'b0;
      if (deliver)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
    if (deliver) begin
      out_depth_mm  <= depth;
      out_in_mask   <= !beyond_r;
      out_frame_end <= box.frame_end;
      out_box_empty <= box.empty;
      out_box_x     <= box.x;
      out_box_y     <= box.y;
      out_box_w     <= box.w;
      out_box_h     <= box.h;
    end
  end

  // an idle block has nothing parked at the chain end
  a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !done_r && !v1_r && !v2_r && !v3_r)
    else $error("pixel in flight while idle");

  // an accepted pixel keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy_r && !in_ready)
    else $error("block not busy after accept");

  // an empty box is only reported at frame end and never with a pixel inside the mask
  a_empty_box: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_box_empty |-> out_frame_end && !out_in_mask)
    else $error("empty box flag out of place");

endmodule

@@ src/dlmb_cell.sv @@
// ----------------------------------------------------------------------------
// dlmb_cell - one restoring division cell
// tries the divisor shifted by SH against the partial remainder, sets one bit
// ----------------------------------------------------------------------------
module dlmb_cell #(
  parameter int W  = 58,
  parameter int SH = 0
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_v,
  input  logic [dlmb_pkg::MM_W-1:0]        in_q,
  input  logic [W-1:0]                     in_rem,
  input  logic [W-1:0]                     in_den,
  output logic                             out_v,
  output logic [dlmb_pkg::MM_W-1:0]        out_q,
  output logic [W-1:0]                     out_rem,
  output logic [W-1:0]                     out_den
);

  logic [W-1:0] trial;
  logic         fits;
  logic [dlmb_pkg::MM_W-1:0] q_nxt;
  logic [W-1:0] rem_nxt;

  assign trial = in_den << SH;
  assign fits  = in_rem >= trial;

  always_comb begin
    q_nxt   = in_q;
    rem_nxt = in_rem;
    if (fits) begin
      q_nxt[SH] = 1'b1;
      rem_nxt   = in_rem - trial;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v <= 1'b0;
    end else begin
      out_v <= in_v;
    end
    out_q   <= q_nxt;
    out_rem <= rem_nxt;
    out_den <= in_den;
  end

endmodule

@@ src/dlmb_box.sv @@
// ----------------------------------------------------------------------------
// dlmb_box - raster position and bounding box tracker
// advances one pixel per step and reports the grown box at frame end
// ----------------------------------------------------------------------------
module dlmb_box (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  logic                        mask,
  input  logic [dlmb_pkg::DIMX_W-1:0] dim_w,
  input  logic [dlmb_pkg::DIMX_W-1:0] dim_h,
  output dlmb_pkg::box_t              box
);

  localparam int PW = dlmb_pkg::POS_W;
  localparam int DW = dlmb_pkg::DIMX_W;

  logic [PW-1:0] col_r, row_r, min_c_r, max_c_r, min_r_r, max_r_r;
  logic          any_r;
  logic [PW-1:0] min_c, max_c, min_r, max_r;
  logic          any_m, last_col, fend;
  logic [DW-1:0] cs, cl, rs, rl;

  function automatic logic [2*DW-1:0] grow(logic [PW-1:0] lo, logic [PW-1:0] hi,
                                          logic [DW-1:0] dim);
    logic [DW-1:0] a, b;
    a = (lo == '0) ? '0 : DW'(lo) - DW'(1);
    b = DW'(hi) + DW'(1);
    if (b > dim - DW'(1)) b = dim - DW'(1);
    if (a > b) a = b;
    return {a, b - a + DW'(1)};
  endfunction

  always_comb begin
    min_c = min_c_r; max_c = max_c_r; min_r = min_r_r; max_r = max_r_r;
    any_m = any_r;
    if (mask) begin
      if (col_r < min_c_r) min_c = col_r;
      if (col_r > max_c_r) max_c = col_r;
      if (row_r < min_r_r) min_r = row_r;
      if (row_r > max_r_r) max_r = row_r;
      any_m = 1'b1;
    end
    last_col = DW'(col_r) >= dim_w - DW'(1);
    fend     = last_col && (DW'(row_r) >= dim_h - DW'(1));
    {cs, cl} = grow(min_c, max_c, dim_w);
    {rs, rl} = grow(min_r, max_r, dim_h);
    box = '0;
    box.frame_end = fend;
    if (fend) begin
      if (any_m) begin
        box.x = cs[PW-1:0];
        box.y = rs[PW-1:0];
        box.w = cl[dlmb_pkg::DIM_W-1:0];
        box.h = rl[dlmb_pkg::DIM_W-1:0];
      end else begin
        box.empty = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0; row_r <= '0;
      min_c_r <= '1; max_c_r <= '0; min_r_r <= '1; max_r_r <= '0;
      any_r <= 1'b0;
    end else if (step) begin
      if (fend) begin
        col_r <= '0; row_r <= '0;
        min_c_r <= '1; max_c_r <= '0; min_r_r <= '1; max_r_r <= '0;
        any_r <= 1'b0;
      end else begin
        min_c_r <= min_c; max_c_r <= max_c; min_r_r <= min_r; max_r_r <= max_r;
        any_r <= any_m;
        if (last_col) begin
          col_r <= '0;
          row_r <= row_r + PW'(1);
        end else begin
          col_r <= col_r + PW'(1);
        end
      end
    end
  end

endmodule
